FILE: hdl/bce_pkg.sv
`default_nettype none

package bce_pkg;

	// ln(2) in Q0.32 and, rounded down, in Q0.16.
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;
	localparam int LN2_Q16 = 45426;

	// Width of one mantissa table entry (Q0.16, always below ln 2).
	localparam int MANT_W = 16;

	// Number of squaring steps used to build the log2 fraction.
	localparam int LOG2_STEPS = 20;

	// ln(1 + idx / 2^tbits) in Q0.16, built from a 20-bit log2 fraction
	// obtained by repeated squaring of a Q1.30 value.
	function automatic logic [MANT_W-1:0] mant_ln(input int tbits, input int idx);
		logic [63:0] y;
		logic [63:0] lg;
		logic [63:0] prod;
		y = (64'(1 << tbits) + 64'(idx)) << (30 - tbits);
		lg = '0;
		for (int b = 0; b < LOG2_STEPS; b++) begin
			y = (y * y) >> 30;
			lg = lg << 1;
			if (y >= 64'h8000_0000) begin
				y = y >> 1;
				lg[0] = 1'b1;
			end
		end
		prod = lg * LN2_Q32 + (64'd1 << 35);
		return prod[36 +: MANT_W];
	endfunction

	// Exponent part of -ln(q), (pfb - k) * ln 2 in Q16.16, for a leading one at position k.
	function automatic logic [63:0] whole_ln(input int pfb, input int k);
		logic [63:0] prod;
		prod = 64'(pfb - k) * LN2_Q32 + (64'd1 << 15);
		return prod >> 16;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/binary_cross_entropy_cost_core.sv
// Binary cross-entropy cost accumulator.
// Input channel (elem_valid/elem_ready) carries one element per request: a
// probability in unsigned fixed point with PROB_FRAC_BITS fraction bits, the
// target bit and a last-element flag. Each element adds -ln(q) to a running
// cost, where q is the probability for a target of one and its complement
// otherwise. The output channel (cost_valid/cost_ready) carries one request
// per vector, produced by the element flagged last: the Q16.16 cost, an error
// flag set when some q was zero, and a saturation flag.
// Throughput is one element per cycle while elem_ready is high. The datapath is
// three registered stages (leading-one detect and normalize, table lookup and
// subtract, accumulate) followed by the output register; the last element passes
// through these in that order before cost_valid rises.
// Reset clears the pipeline valids, the accumulator and both sticky flags.
// While a result waits in the output register and cost_ready is low, the
// whole pipeline holds and elem_ready is low; accepting the result frees it
// in the same cycle.
`default_nettype none

module binary_cross_entropy_cost_core #(
	parameter int PROB_FRAC_BITS = 16,
	parameter int COST_WIDTH = 32,
	parameter int LOG_TABLE_BITS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      elem_valid,
	output logic                           elem_ready,
	input  wire logic [PROB_FRAC_BITS:0]   probability,
	input  wire logic                      target_bit,
	input  wire logic                      last_element,
	output logic                           cost_valid,
	input  wire logic                      cost_ready,
	output logic [31:0]                    total_cost,
	output logic                           cost_error,
	output logic                           cost_saturated
);

	localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;
	localparam int TERM_W = $clog2(PROB_FRAC_BITS * (bce_pkg::LN2_Q16 + 1) + 1);
	localparam int K_W = $clog2(PROB_FRAC_BITS);
	localparam logic [K_W-1:0] K_TOP = K_W'(PROB_FRAC_BITS - 1);
	localparam logic [PROB_FRAC_BITS:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
	localparam logic [COST_WIDTH-1:0] COST_MAX = '1;
	localparam logic [COST_WIDTH+31:0] COST_MAX_EXT = {32'b0, COST_MAX};

	typedef logic [bce_pkg::MANT_W-1:0] mant_tbl_t [TABLE_SIZE];
	typedef logic [TERM_W-1:0] whole_tbl_t [PROB_FRAC_BITS];

	function automatic mant_tbl_t build_mant_tbl();
		mant_tbl_t tbl;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl[i] = bce_pkg::mant_ln(LOG_TABLE_BITS, i);
		end
		return tbl;
	endfunction

	function automatic whole_tbl_t build_whole_tbl();
		whole_tbl_t tbl;
		logic [63:0] w;
		for (int i = 0; i < PROB_FRAC_BITS; i++) begin
			w = bce_pkg::whole_ln(PROB_FRAC_BITS, i);
			tbl[i] = w[TERM_W-1:0];
		end
		return tbl;
	endfunction

	localparam mant_tbl_t MANT_LN = build_mant_tbl();
	localparam whole_tbl_t WHOLE_LN = build_whole_tbl();

	logic adv;

	// Stage 1: registered input.
	logic                    vld_s1;
	logic [PROB_FRAC_BITS:0] prob_s1;
	logic                    tgt_s1;
	logic                    last_s1;

	// Stage 1 logic: form q, find its leading one and the mantissa index.
	logic [PROB_FRAC_BITS:0]                  p_clamp_c;
	logic [PROB_FRAC_BITS:0]                  q_c;
	logic [PROB_FRAC_BITS-1:0]                q_frac_c;
	logic [K_W-1:0]                           k_c;
	logic [PROB_FRAC_BITS-1:0]                norm_c;
	logic [PROB_FRAC_BITS+LOG_TABLE_BITS-2:0] ext_c;
	logic [LOG_TABLE_BITS-1:0]                idx_c;
	logic                                     zero_c;
	logic                                     act_c;

	// Stage 2.
	logic                      vld_s2;
	logic                      last_s2;
	logic                      zero_s2;
	logic                      act_s2;
	logic [K_W-1:0]            k_s2;
	logic [LOG_TABLE_BITS-1:0] idx_s2;

	logic [TERM_W-1:0]              whole_c;
	logic [bce_pkg::MANT_W-1:0]     mant_c;
	logic [TERM_W-1:0]              term_c;

	// Stage 3.
	logic              vld_s3;
	logic              last_s3;
	logic              zero_s3;
	logic [TERM_W-1:0] term_s3;

	// Accumulator and output register.
	logic [COST_WIDTH-1:0]  acc_q;
	logic                   err_q;
	logic                   sat_q;
	logic [COST_WIDTH:0]    sum_c;
	logic                   ovf_c;
	logic [COST_WIDTH-1:0]  acc_new_c;
	logic                   err_new_c;
	logic                   sat_new_c;
	logic [COST_WIDTH+31:0] acc_ext_c;

	logic        cost_valid_q;
	logic [31:0] total_cost_q;
	logic        cost_error_q;
	logic        cost_saturated_q;

	assign adv = !cost_valid_q || cost_ready;
	assign elem_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= elem_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prob_s1 <= probability;
			tgt_s1  <= target_bit;
			last_s1 <= last_element;
			last_s2 <= last_s1;
			zero_s2 <= zero_c;
			act_s2  <= act_c;
			k_s2    <= k_c;
			idx_s2  <= idx_c;
			last_s3 <= last_s2;
			zero_s3 <= zero_s2;
			term_s3 <= term_c;
		end
	end

	always_comb begin
		p_clamp_c = (prob_s1 > PROB_ONE) ? PROB_ONE : prob_s1;
		q_c = tgt_s1 ? p_clamp_c : (PROB_ONE - p_clamp_c);
		q_frac_c = q_c[PROB_FRAC_BITS-1:0];
		zero_c = (q_c == '0);
		act_c = !zero_c && (q_c != PROB_ONE);
		k_c = '0;
		for (int i = 0; i < PROB_FRAC_BITS; i++) begin
			if (q_frac_c[i]) begin
				k_c = K_W'(i);
			end
		end
		norm_c = q_frac_c << (K_TOP - k_c);
		ext_c = {norm_c[PROB_FRAC_BITS-2:0], {LOG_TABLE_BITS{1'b0}}};
		idx_c = ext_c[PROB_FRAC_BITS+LOG_TABLE_BITS-2 -: LOG_TABLE_BITS];
	end

	always_comb begin
		whole_c = WHOLE_LN[k_s2];
		mant_c = MANT_LN[idx_s2];
		if (act_s2 && (whole_c >= TERM_W'(mant_c))) begin
			term_c = whole_c - TERM_W'(mant_c);
		end else begin
			term_c = '0;
		end
	end

	always_comb begin
		sum_c = {1'b0, acc_q} + (COST_WIDTH + 1)'(term_s3);
		ovf_c = sum_c[COST_WIDTH];
		acc_new_c = ovf_c ? COST_MAX : sum_c[COST_WIDTH-1:0];
		err_new_c = err_q || zero_s3;
		sat_new_c = sat_q || ovf_c;
		acc_ext_c = {32'b0, acc_new_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= 1'b0;
			sat_q <= 1'b0;
			cost_valid_q <= 1'b0;
		end else if (adv) begin
			cost_valid_q <= vld_s3 && last_s3;
			if (vld_s3) begin
				if (last_s3) begin
					acc_q <= '0;
					err_q <= 1'b0;
					sat_q <= 1'b0;
				end else begin
					acc_q <= acc_new_c;
					err_q <= err_new_c;
					sat_q <= sat_new_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3 && last_s3) begin
			total_cost_q     <= acc_ext_c[31:0];
			cost_error_q     <= err_new_c;
			cost_saturated_q <= sat_new_c;
		end
	end

	assign cost_valid     = cost_valid_q;
	assign total_cost     = total_cost_q;
	assign cost_error     = cost_error_q;
	assign cost_saturated = cost_saturated_q;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid && !cost_ready |=> $stable(acc_q) && $stable(err_q) && $stable(sat_q))
		else $error("accumulator changed while the output was stalled");

	a_last_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && last_s3 && adv |=> cost_valid)
		else $error("last element did not produce a result");

	a_last_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && last_s3 && adv |=> acc_q == '0 && !err_q && !sat_q)
		else $error("state not cleared after the last element");

	a_saturated_value: assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid && cost_saturated |-> total_cost == COST_MAX_EXT[31:0])
		else $error("saturated result does not hold the maximum cost");

endmodule

`default_nettype wire

FILE: sim/bce_checker.sv
module bce_checker #(
	parameter int PROB_FRAC_BITS = 16,
	parameter int COST_WIDTH = 32,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      elem_valid,
	input  logic                      elem_ready,
	input  logic [PROB_FRAC_BITS:0]   probability,
	input  logic                      target_bit,
	input  logic                      last_element,
	input  logic                      cost_valid,
	input  logic                      cost_ready,
	input  logic [31:0]               total_cost,
	input  logic                      cost_error,
	input  logic                      cost_saturated,
	output int                        mismatches,
	output int                        expected_left,
	output int                        elements_seen,
	output int                        results_seen,
	output int                        error_results,
	output int                        saturated_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] cost;
		logic        err;
		logic        sat;
	} cost_result_t;

	localparam int TABLE_DEPTH = 1 << LOG_TABLE_BITS;
	localparam logic [63:0] ONE_PROB = 64'd1 << PROB_FRAC_BITS;
	localparam logic [63:0] SUM_MAX = (64'd1 << COST_WIDTH) - 64'd1;

	logic [63:0] ln_frac_table [0:TABLE_DEPTH-1];
	logic [63:0] cost_sum = '0;
	logic error_seen = 1'b0;
	logic clamp_seen = 1'b0;
	cost_result_t expected_costs [$];
	int n_mis = 0;
	int n_elem = 0;
	int n_res = 0;
	int n_err = 0;
	int n_sat = 0;

	initial begin : build_table
		logic [63:0] y;
		logic [63:0] lg;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			y = (64'(TABLE_DEPTH) + 64'(i)) << (30 - LOG_TABLE_BITS);
			lg = '0;
			for (int b = 0; b < 20; b++) begin
				y = (y * y) >> 30;
				lg = lg << 1;
				if (y >= 64'h8000_0000) begin
					y = y >> 1;
					lg[0] = 1'b1;
				end
			end
			ln_frac_table[i] = (lg * bce_pkg::LN2_Q32 + (64'd1 << 35)) >> 36;
		end
	end

	// Cost -ln(q) in Q16.16 for a q strictly between zero and one.
	function automatic logic [63:0] nat_log_cost(input logic [63:0] q);
		int k;
		logic [LOG_TABLE_BITS-1:0] idx;
		logic [63:0] whole;
		k = PROB_FRAC_BITS - 1;
		while (k > 0 && q[k] == 1'b0)
			k--;
		if (k >= LOG_TABLE_BITS)
			idx = LOG_TABLE_BITS'(q >> (k - LOG_TABLE_BITS));
		else
			idx = LOG_TABLE_BITS'(q << (LOG_TABLE_BITS - k));
		whole = (64'(PROB_FRAC_BITS - k) * bce_pkg::LN2_Q32 + (64'd1 << 15)) >> 16;
		if (whole < ln_frac_table[idx])
			return '0;
		return whole - ln_frac_table[idx];
	endfunction

	task automatic accumulate_element(input logic [PROB_FRAC_BITS:0] p_in, input logic tgt,
			input logic lst);
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] term;
		p = 64'(p_in);
		if (p > ONE_PROB)
			p = ONE_PROB;
		q = tgt ? p : ONE_PROB - p;
		if (q == 0) begin
			error_seen = 1'b1;
		end else if (q < ONE_PROB) begin
			term = nat_log_cost(q);
			if (term > SUM_MAX - cost_sum) begin
				cost_sum = SUM_MAX;
				clamp_seen = 1'b1;
			end else begin
				cost_sum = cost_sum + term;
			end
		end
		if (lst) begin
			expected_costs.push_back('{cost: cost_sum[31:0], err: error_seen, sat: clamp_seen});
			cost_sum = '0;
			error_seen = 1'b0;
			clamp_seen = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		n_mis++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		cost_result_t want;
		if (!arst_n) begin
			cost_sum = '0;
			error_seen = 1'b0;
			clamp_seen = 1'b0;
			expected_costs.delete();
		end else begin
			if (cost_valid && cost_ready) begin
				n_res++;
				if (cost_error)
					n_err++;
				if (cost_saturated)
					n_sat++;
				if (expected_costs.size() == 0) begin
					report_mismatch($sformatf("cost request %h/%b/%b with none pending",
						total_cost, cost_error, cost_saturated));
				end else begin
					want = expected_costs.pop_front();
					if (total_cost !== want.cost)
						report_mismatch($sformatf("total_cost %h, expected %h",
							total_cost, want.cost));
					if (cost_error !== want.err)
						report_mismatch($sformatf("cost_error %b, expected %b",
							cost_error, want.err));
					if (cost_saturated !== want.sat)
						report_mismatch($sformatf("cost_saturated %b, expected %b",
							cost_saturated, want.sat));
				end
			end
			if (elem_valid && elem_ready) begin
				n_elem++;
				accumulate_element(probability, target_bit, last_element);
			end
		end
		mismatches <= n_mis;
		expected_left <= expected_costs.size();
		elements_seen <= n_elem;
		results_seen <= n_res;
		error_results <= n_err;
		saturated_results <= n_sat;
	end

endmodule

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROB_FRAC_BITS = 16;
	localparam int COST_WIDTH = 32;
	localparam int LOG_TABLE_BITS = 8;

	typedef logic [PROB_FRAC_BITS:0] prob_t;

	localparam prob_t PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
	localparam prob_t PROB_ALL = '1;
	localparam int RANDOM_ITEMS = 2000;
	localparam int IDLE_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic elem_valid = 1'b0;
	logic elem_ready;
	logic [PROB_FRAC_BITS:0] probability = '0;
	logic target_bit = 1'b0;
	logic last_element = 1'b0;
	logic cost_valid;
	logic cost_ready = 1'b0;
	logic [31:0] total_cost;
	logic cost_error;
	logic cost_saturated;

	int mismatches;
	int expected_left;
	int elements_seen;
	int results_seen;
	int error_results;
	int saturated_results;

	int burst_left = 0;
	int elems_sent = 0;

	binary_cross_entropy_cost_core #(
		.PROB_FRAC_BITS(PROB_FRAC_BITS),
		.COST_WIDTH(COST_WIDTH),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.probability(probability),
		.target_bit(target_bit),
		.last_element(last_element),
		.cost_valid(cost_valid),
		.cost_ready(cost_ready),
		.total_cost(total_cost),
		.cost_error(cost_error),
		.cost_saturated(cost_saturated)
	);

	bce_checker #(
		.PROB_FRAC_BITS(PROB_FRAC_BITS),
		.COST_WIDTH(COST_WIDTH),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_cost_check (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.probability(probability),
		.target_bit(target_bit),
		.last_element(last_element),
		.cost_valid(cost_valid),
		.cost_ready(cost_ready),
		.total_cost(total_cost),
		.cost_error(cost_error),
		.cost_saturated(cost_saturated),
		.mismatches(mismatches),
		.expected_left(expected_left),
		.elements_seen(elements_seen),
		.results_seen(results_seen),
		.error_results(error_results),
		.saturated_results(saturated_results)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The sender works in bursts; a gap of zero joins two bursts into one.
	task automatic push_element(input logic [PROB_FRAC_BITS:0] p, input logic t,
			input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				elem_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		elem_valid <= 1'b1;
		probability <= p;
		target_bit <= t;
		last_element <= l;
		do @(posedge clk); while (!elem_ready);
		elems_sent++;
	endtask

	function automatic logic [PROB_FRAC_BITS:0] random_probability();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
				0: return '0;
				1: return prob_t'(1);
				2: return PROB_ONE - prob_t'(1);
				3: return PROB_ONE;
				default: return PROB_ALL;
			endcase
		end else if (pick == 1) begin
			return prob_t'($urandom_range(PROB_ONE + prob_t'(1), PROB_ALL));
		end else if (pick <= 4) begin
			return prob_t'($urandom_range(1, 300));
		end else if (pick <= 7) begin
			return PROB_ONE - prob_t'($urandom_range(1, 300));
		end
		return prob_t'($urandom_range(0, PROB_ONE));
	endfunction

	task automatic send_vector(input int len);
		for (int i = 0; i < len; i++)
			push_element(random_probability(), 1'($urandom_range(0, 1)), i == len - 1);
	endtask

	initial begin : stimulus
		int random_start;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_element('0, 1'b0, 1'b1);
		push_element('0, 1'b1, 1'b0);
		push_element(PROB_ONE >> 1, 1'b1, 1'b0);
		push_element(PROB_ONE - prob_t'(1), 1'b1, 1'b1);
		push_element(PROB_ONE, 1'b1, 1'b0);
		push_element(PROB_ONE, 1'b0, 1'b0);
		push_element(PROB_ALL, 1'b1, 1'b0);
		push_element(PROB_ALL, 1'b0, 1'b0);
		push_element(PROB_ONE + prob_t'(1), 1'b0, 1'b1);
		push_element(prob_t'(1), 1'b1, 1'b0);
		push_element(PROB_ONE - prob_t'(1), 1'b0, 1'b0);
		push_element(17'h000FF, 1'b1, 1'b0);
		push_element(17'h00100, 1'b1, 1'b0);
		push_element(17'h0AAAA, 1'b0, 1'b0);
		push_element(17'h05555, 1'b1, 1'b1);
		push_element(17'd12345, 1'b0, 1'b1);
		push_element(PROB_ALL, 1'b1, 1'b1);

		random_start = elems_sent;
		while (elems_sent - random_start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				send_vector(1);
			else if (pick == 9)
				send_vector($urandom_range(20, 80));
			else
				send_vector($urandom_range(2, 12));
		end
		elem_valid <= 1'b0;

		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d elements in directed corner cases and random vectors,",
			elements_seen);
		$display("%0d costs checked, %0d with error, %0d saturated.",
			results_seen, error_results, saturated_results);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : receiver
		@(posedge clk);
		forever begin
			cost_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if ($urandom_range(0, 3) != 0) begin
				cost_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((elem_valid && elem_ready) || (cost_valid && cost_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Timeout: no request moved for %0d cycles.", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
hdl/bce_pkg.sv
hdl/binary_cross_entropy_cost_core.sv
sim/bce_checker.sv
sim/testbench.sv
